FILE: rtl/krt_pkg.sv
`default_nettype none

package krt_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned USED_W = 5;

  localparam logic [7:0] GRADE_LIMIT = 8'd100;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  // record payload without the key
  typedef struct packed {
    logic [7:0] grade_c;
    logic [7:0] grade_b;
    logic [7:0] grade_a;
    logic [7:0] course_c;
    logic [7:0] course_b;
    logic [7:0] course_a;
    logic [7:0] year;
  } data_t;

  // one store word, key in the low byte
  typedef struct packed {
    data_t      data;
    logic [7:0] key;
  } rec_t;

  typedef struct packed {
    logic              ok;
    data_t             data;
    logic [7:0]        listed;
    logic [USED_W-1:0] used;
    logic              full;
    logic              last;
  } res_t;

  function automatic logic [USED_W-1:0] to_used(input logic [CNT_W-1:0] cnt);
    logic [USED_W+CNT_W-1:0] tmp;
    tmp = {{USED_W{1'b0}}, cnt};
    return tmp[USED_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/keyed_record_table.sv
// channel | ports                                  | handshake
// --------+----------------------------------------+-------------------------------------
// input   | in_op, in_key, in_year_in, in_course_*,| taken when start is high, busy low
//         | in_grade_*                             |
// result  | out_ok, out_*_out, out_listed_key,     | out_valid high for one cycle, always
//         | out_used_count, out_is_full, out_last  | taken
//
// one entry per cycle through the single registered read port; a scan stops at a hit or
//   at the end of the table (an empty table is not read), and a delete hit then moves
//   later records down one per cycle
// list strobes keys on back-to-back cycles, last one flagged
// synchronous active-low reset empties the table; memory contents need no clearing
// results cannot be held off; busy stays high until the final result of an item
`default_nettype none

module keyed_record_table (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_key,
  input  wire logic [7:0] in_year_in,
  input  wire logic [7:0] in_course_a_in,
  input  wire logic [7:0] in_course_b_in,
  input  wire logic [7:0] in_course_c_in,
  input  wire logic [7:0] in_grade_a_in,
  input  wire logic [7:0] in_grade_b_in,
  input  wire logic [7:0] in_grade_c_in,
  output logic            out_valid,
  output logic            out_ok,
  output logic [7:0]      out_year_out,
  output logic [7:0]      out_course_a_out,
  output logic [7:0]      out_course_b_out,
  output logic [7:0]      out_course_c_out,
  output logic [7:0]      out_grade_a_out,
  output logic [7:0]      out_grade_b_out,
  output logic [7:0]      out_grade_c_out,
  output logic [7:0]      out_listed_key,
  output logic [4:0]      out_used_count,
  output logic            out_is_full,
  output logic            out_last
);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  krt_pkg::op_t                     op_r, op_nxt;
  krt_pkg::rec_t                    rec_r, rec_nxt;       // latched item
  logic [krt_pkg::CNT_W-1:0]        count_r, count_nxt;   // records stored
  logic [krt_pkg::CNT_W-1:0]        idx_r, idx_nxt;       // next address to read
  logic [krt_pkg::IDX_W-1:0]        pidx_r, pidx_nxt;     // address of rdata_r
  logic                             pend_r, pend_nxt;     // rdata_r holds a live entry
  krt_pkg::res_t                    res_r, res_nxt;
  logic                             vld_r, vld_nxt;

  // record memory, one write and one registered read port
  krt_pkg::rec_t                    mem [krt_pkg::DEPTH];
  krt_pkg::rec_t                    rdata_r;
  logic                             wr_en;
  logic [krt_pkg::IDX_W-1:0]        wr_addr;
  krt_pkg::rec_t                    wr_data;

  logic                             issue;
  logic                             hit;
  logic                             grades_ok;
  logic                             list_last;

  assign busy  = (state_r != S_IDLE);
  assign issue = (idx_r < count_r);
  // the shared key comparator
  assign hit   = pend_r && (rdata_r.key == rec_r.key);

  assign grades_ok = (rec_r.data.grade_a <= krt_pkg::GRADE_LIMIT) &&
                     (rec_r.data.grade_b <= krt_pkg::GRADE_LIMIT) &&
                     (rec_r.data.grade_c <= krt_pkg::GRADE_LIMIT);

  assign list_last = ((krt_pkg::CNT_W'({1'b0, pidx_r}) + krt_pkg::CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    rec_nxt   = rec_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pidx_nxt  = idx_r[krt_pkg::IDX_W-1:0];
    pend_nxt  = 1'b0;
    res_nxt   = res_r;
    vld_nxt   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = count_r[krt_pkg::IDX_W-1:0];
    wr_data   = rec_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt                = krt_pkg::op_t'(in_op);
          rec_nxt.key           = in_key;
          rec_nxt.data.year     = in_year_in;
          rec_nxt.data.course_a = in_course_a_in;
          rec_nxt.data.course_b = in_course_b_in;
          rec_nxt.data.course_c = in_course_c_in;
          rec_nxt.data.grade_a  = in_grade_a_in;
          rec_nxt.data.grade_b  = in_grade_b_in;
          rec_nxt.data.grade_c  = in_grade_c_in;
          idx_nxt               = '0;
          state_nxt             = S_SCAN;
        end
      end

      S_SCAN: begin
        if (pend_r && (op_r == krt_pkg::OP_LIST)) begin
          // one key out per entry
          vld_nxt        = 1'b1;
          res_nxt        = '0;
          res_nxt.ok     = 1'b1;
          res_nxt.listed = rdata_r.key;
          res_nxt.last   = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else if (issue) begin
            pend_nxt = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
        end else if (hit) begin
          priority case (op_r)
            krt_pkg::OP_READ: begin
              vld_nxt      = 1'b1;
              res_nxt      = '0;
              res_nxt.ok   = 1'b1;
              res_nxt.data = rdata_r.data;
              res_nxt.last = 1'b1;
              state_nxt    = S_IDLE;
            end
            krt_pkg::OP_DELETE: begin
              // move later records down over the hit
              idx_nxt   = {1'b0, pidx_r} + 1'b1;
              state_nxt = S_SHIFT;
            end
            default: begin
              // add of a key already stored
              vld_nxt      = 1'b1;
              res_nxt      = '0;
              res_nxt.last = 1'b1;
              state_nxt    = S_IDLE;
            end
          endcase
        end else if (issue) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          // scan done without a hit
          vld_nxt      = 1'b1;
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          state_nxt    = S_IDLE;
          if ((op_r == krt_pkg::OP_ADD) && grades_ok &&
              (count_r < krt_pkg::CNT_W'(krt_pkg::DEPTH))) begin
            wr_en      = 1'b1;
            count_nxt  = count_r + 1'b1;
            res_nxt.ok = 1'b1;
          end
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r - 1'b1;
          wr_data = rdata_r;
        end
        if (issue) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          count_nxt    = count_r - 1'b1;
          vld_nxt      = 1'b1;
          res_nxt      = '0;
          res_nxt.ok   = 1'b1;
          res_nxt.last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // status always reflects the table after this operation
    if (vld_nxt) begin
      res_nxt.used = krt_pkg::to_used(count_nxt);
      res_nxt.full = (count_nxt == krt_pkg::CNT_W'(krt_pkg::DEPTH));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    rec_r  <= rec_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    res_r  <= res_nxt;
  end

  // record memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[idx_r[krt_pkg::IDX_W-1:0]];
  end

  assign out_valid        = vld_r;
  assign out_ok           = res_r.ok;
  assign out_year_out     = res_r.data.year;
  assign out_course_a_out = res_r.data.course_a;
  assign out_course_b_out = res_r.data.course_b;
  assign out_course_c_out = res_r.data.course_c;
  assign out_grade_a_out  = res_r.data.grade_a;
  assign out_grade_b_out  = res_r.data.grade_b;
  assign out_grade_c_out  = res_r.data.grade_c;
  assign out_listed_key   = res_r.listed;
  assign out_used_count   = res_r.used;
  assign out_is_full      = res_r.full;
  assign out_last         = res_r.last;

  // table never overfills
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= krt_pkg::CNT_W'(krt_pkg::DEPTH))
    else $error("record count above table depth");

  // the final result of an item frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.last) |-> !busy)
    else $error("busy after final result");

  // no result in the cycle after an item is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !vld_r)
    else $error("result right after accept");

  // results come only out of a working state
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    vld_nxt |-> busy)
    else $error("result raised while idle");

endmodule

`default_nettype wire
